[rtl/cgd_pkg.sv]
// shared types and constants for the gridding and degridding unit
package cgd_pkg;

   localparam int GridSide    = 256;
   localparam int GridAw      = 8;
   localparam int CellAw      = 2 * GridAw;
   localparam int KernelDepth = 131072;
   localparam int KernelAw    = 17;
   localparam int MaxSupport  = 7;

   localparam logic [2:0] REQ_LOAD   = 3'd0;
   localparam logic [2:0] REQ_GRID   = 3'd1;
   localparam logic [2:0] REQ_DEGRID = 3'd2;
   localparam logic [2:0] REQ_READ   = 3'd3;
   localparam logic [2:0] REQ_WRITE  = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_GRID   = 2'd1;
   localparam logic [1:0] ST_KERNEL = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       clr_we;       // clear-pass write
      logic       lat;          // latch request
      logic       acc_clr;      // start of window
      logic       rd;           // issue reads at current window position
      logic       step;         // advance window position
      logic       mac;          // read data valid: multiply stage
      logic       upd;          // product valid: accumulate or write back
      logic       fin;          // load result register
      logic       kload;        // write kernel word
      logic       cwrite;       // write cell
   } cgd_cmd_type;

   typedef struct packed {
      logic       last;         // window position is the last one
      logic       clr_done;
   } cgd_stat_type;

endpackage

[rtl/cgd_ram.sv]
// generic single-port-write, one-read RAM with registered read data
module cgd_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/cgd_datapath.sv]
// grid and kernel memories, window addressing, complex mac and result register
module cgd_datapath import cgd_pkg::*; (
   input  logic               clock,
   input  cgd_cmd_type        cmd,
   output cgd_stat_type       stat,
   input  logic [2:0]         s_in,
   input  logic [2:0]         req_type,
   input  logic signed [15:0] sample_re,
   input  logic signed [15:0] sample_im,
   input  logic [7:0]         grid_u,
   input  logic [7:0]         grid_v,
   input  logic [16:0]        kernel_base,
   input  logic signed [31:0] cell_re,
   input  logic signed [31:0] cell_im,
   input  logic [1:0]         fin_status,
   output logic signed [31:0] rsp_result_re,
   output logic signed [31:0] rsp_result_im,
   output logic               rsp_saturated,
   output logic [1:0]         rsp_status
);
   logic [2:0]         type_ff;
   logic signed [15:0] sre_ff, sim_ff;
   logic [7:0]         u_ff, v_ff;
   logic [16:0]        base_ff;
   logic signed [31:0] cre_ff, cim_ff;
   logic [2:0]         s_ff;
   logic [3:0]         side_ff;
   logic [3:0]         r_ff, c_ff;
   logic [16:0]        ka_ff;
   logic [CellAw-1:0]  clr_ff;
   logic [CellAw-1:0]  ga_ff, ga1_ff;
   logic               sat_ff;
   logic signed [40:0] acc_re_ff, acc_im_ff;
   logic signed [33:0] pr_ff, pi_ff;
   logic signed [31:0] g1re_ff, g1im_ff;
   logic signed [48:0] pre, pim;
   logic signed [47:0] m_rr, m_ii, m_ri, m_ir;

   logic [31:0]        krd;
   logic [63:0]        grd, gwd;
   logic [CellAw-1:0]  gwa, cur_ga;
   logic               gwe;
   logic signed [15:0] kre, kim, mre, mim;
   logic signed [31:0] gre, gim, opr, opi;
   logic signed [32:0] sum_re, sum_im;
   logic signed [31:0] clip_re, clip_im;
   logic               cs_re, cs_im;

   assign cur_ga = {v_ff + {4'd0, r_ff}, u_ff - {5'd0, s_ff} + {4'd0, c_ff}};
   assign stat.last = (r_ff == side_ff - 4'd1) && (c_ff == side_ff - 4'd1);
   assign stat.clr_done = &clr_ff;

   cgd_ram #(.Width(32), .Depth(KernelDepth)) u_kern (
      .clock(clock), .wr_en(cmd.kload), .wr_addr(base_ff),
      .wr_data({sre_ff, sim_ff}), .rd_addr(ka_ff), .rd_data(krd));

   cgd_ram #(.Width(64), .Depth(GridSide * GridSide)) u_grid (
      .clock(clock), .wr_en(gwe), .wr_addr(gwa), .wr_data(gwd),
      .rd_addr(cmd.rd ? cur_ga : {v_ff, u_ff}), .rd_data(grd));

   assign kre = krd[31:16];
   assign kim = krd[15:0];
   assign gre = grd[63:32];
   assign gim = grd[31:0];
   // gridding multiplies the sample, degridding the cell
   assign mre = sre_ff;
   assign mim = sim_ff;
   always_comb begin
      if (type_ff == REQ_GRID) begin
         m_rr = 48'(mre) * 48'(kre);
         m_ii = 48'(mim) * 48'(kim);
         m_ri = 48'(mre) * 48'(kim);
         m_ir = 48'(mim) * 48'(kre);
      end else begin
         m_rr = 48'(gre) * 48'(kre);
         m_ii = 48'(gim) * 48'(kim);
         m_ri = 48'(gre) * 48'(kim);
         m_ir = 48'(gim) * 48'(kre);
      end
      pre = 49'(m_rr) - 49'(m_ii);
      pim = 49'(m_ri) + 49'(m_ir);
   end

   assign opr = g1re_ff;
   assign opi = g1im_ff;
   // gridding products stay well inside 33 bits
   assign sum_re = 33'(opr) + $signed(pr_ff[32:0]);
   assign sum_im = 33'(opi) + $signed(pi_ff[32:0]);
   always_comb begin
      cs_re = 1'b0;
      cs_im = 1'b0;
      clip_re = sum_re[31:0];
      clip_im = sum_im[31:0];
      if (sum_re[32] != sum_re[31]) begin
         cs_re = 1'b1;
         clip_re = sum_re[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      if (sum_im[32] != sum_im[31]) begin
         cs_im = 1'b1;
         clip_im = sum_im[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
   end

   always_comb begin
      gwe = 1'b0;
      gwa = ga1_ff;
      gwd = {clip_re, clip_im};
      if (cmd.clr_we) begin
         gwe = 1'b1;
         gwa = clr_ff;
         gwd = '0;
      end else if (cmd.cwrite) begin
         gwe = 1'b1;
         gwa = {v_ff, u_ff};
         gwd = {cre_ff, cim_ff};
      end else if (cmd.upd && type_ff == REQ_GRID) begin
         gwe = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_we) begin
         clr_ff <= clr_ff + 1'b1;
      end else begin
         clr_ff <= '0;
      end
      if (cmd.lat) begin
         type_ff <= req_type;
         sre_ff  <= sample_re;
         sim_ff  <= sample_im;
         u_ff    <= grid_u;
         v_ff    <= grid_v;
         base_ff <= kernel_base;
         cre_ff  <= cell_re;
         cim_ff  <= cell_im;
         s_ff    <= s_in;
         side_ff <= {s_in, 1'b1};
      end
      if (cmd.acc_clr) begin
         r_ff      <= '0;
         c_ff      <= '0;
         ka_ff     <= base_ff;
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         sat_ff    <= 1'b0;
      end else begin
         if (cmd.step) begin
            ka_ff <= ka_ff + 17'd1;
            if (c_ff == side_ff - 4'd1) begin
               c_ff <= '0;
               r_ff <= r_ff + 4'd1;
            end else begin
               c_ff <= c_ff + 4'd1;
            end
         end
         if (cmd.upd) begin
            if (type_ff == REQ_GRID) begin
               sat_ff <= sat_ff | cs_re | cs_im;
            end else begin
               acc_re_ff <= acc_re_ff + 41'(pr_ff);
               acc_im_ff <= acc_im_ff + 41'(pi_ff);
            end
         end
      end
      if (cmd.rd) begin
         ga_ff <= cur_ga;
      end
      if (cmd.mac) begin
         // arithmetic shift is floor division by 2^15
         pr_ff   <= 34'(pre >>> 15);
         pi_ff   <= 34'(pim >>> 15);
         g1re_ff <= gre;
         g1im_ff <= gim;
         ga1_ff  <= ga_ff;
      end
      if (cmd.fin) begin
         rsp_status    <= fin_status;
         rsp_saturated <= 1'b0;
         rsp_result_re <= '0;
         rsp_result_im <= '0;
         if (fin_status == ST_OK) begin
            if (type_ff == REQ_READ) begin
               rsp_result_re <= gre;
               rsp_result_im <= gim;
            end else if (type_ff == REQ_GRID) begin
               rsp_saturated <= sat_ff;
            end else if (type_ff == REQ_DEGRID) begin
               rsp_result_re <= acc_re_ff[31:0];
               rsp_result_im <= acc_im_ff[31:0];
               if (acc_re_ff > 41'sh0_7fff_ffff) begin
                  rsp_result_re <= 32'sh7fff_ffff;
                  rsp_saturated <= 1'b1;
               end else if (acc_re_ff < -41'sh0_8000_0000) begin
                  rsp_result_re <= 32'sh8000_0000;
                  rsp_saturated <= 1'b1;
               end
               if (acc_im_ff > 41'sh0_7fff_ffff) begin
                  rsp_result_im <= 32'sh7fff_ffff;
                  rsp_saturated <= 1'b1;
               end else if (acc_im_ff < -41'sh0_8000_0000) begin
                  rsp_result_im <= 32'sh8000_0000;
                  rsp_saturated <= 1'b1;
               end
            end
         end
      end
   end
endmodule

[rtl/cgd_controller.sv]
// sequencer for clearing, request checks, window walk and result strobe
module cgd_controller import cgd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [2:0]   req_type,
   input  logic [7:0]   grid_u,
   input  logic [7:0]   grid_v,
   input  logic [16:0]  kernel_base,
   input  logic [2:0]   s_in,
   input  cgd_stat_type stat,
   output cgd_cmd_type  cmd,
   output logic [1:0]   fin_status,
   output logic         busy,
   output logic         rsp_valid
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_WALK, S_DRAIN, S_WAIT, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] drain_ff, drain_in;
   logic [1:0] st_ff, st_in;
   logic       last_ff, last_in;
   logic       mac_ff, upd_ff;
   logic [8:0] lo, hi, vend;
   logic [17:0] kend;
   logic [7:0]  sq;
   logic [1:0]  chk;
   logic [2:0]  t_ff;
   logic        kload_ok, cell_ok;

   // window limits against the grid and the kernel table
   assign lo   = {1'b0, grid_u};
   assign hi   = {1'b0, grid_u} + {6'd0, s_in};
   assign vend = {1'b0, grid_v} + {5'd0, s_in, 1'b0};
   assign sq   = {4'd0, s_in, 1'b1} * {4'd0, s_in, 1'b1};
   assign kend = {1'b0, kernel_base} + {10'd0, sq};
   always_comb begin
      if (lo < {6'd0, s_in} || hi >= 9'(GridSide) || vend >= 9'(GridSide)) begin
         chk = ST_GRID;
      end else if (kend > 18'(KernelDepth)) begin
         chk = ST_KERNEL;
      end else begin
         chk = ST_OK;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign fin_status = st_ff;

   // enables for the side effects that depend on the latched request, both tied high
   assign kload_ok = 1'b1;
   assign cell_ok  = 1'b1;

   always_comb begin
      state_in = state_ff;
      drain_in = drain_ff;
      st_in    = st_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.mac  = mac_ff;
      cmd.upd  = upd_ff;
      // the finish strobe comes from the done state, single-cycle writes from the wait state and the latched type
      cmd.fin    = (state_ff == S_DONE);
      cmd.kload  = (state_ff == S_WAIT) && (t_ff == REQ_LOAD) && kload_ok;
      cmd.cwrite = (state_ff == S_WAIT) && (t_ff == REQ_WRITE) && cell_ok;
      case (state_ff)
         S_CLEAR: begin
            // clear address counter holds at zero while reset is high
            cmd.clr_we = !reset;
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.lat = 1'b1;
               st_in   = ST_OK;
               state_in = S_DONE;
               case (req_type)
                  REQ_LOAD: begin
                     state_in = S_WAIT;
                  end
                  REQ_GRID, REQ_DEGRID: begin
                     st_in = chk;
                     if (chk == ST_OK) begin
                        state_in = S_WALK;
                     end
                  end
                  REQ_READ, REQ_WRITE: begin
                     state_in = S_WAIT;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
               if (req_type == REQ_GRID || req_type == REQ_DEGRID) begin
                  drain_in = 2'd0;
               end
            end
         end
         S_WALK: begin
            if (drain_ff == 2'd0 && !last_ff) begin
               // first cycle: reset window counters
               cmd.acc_clr = 1'b1;
               drain_in = 2'd1;
               last_in  = 1'b0;
            end else begin
               cmd.rd   = 1'b1;
               cmd.step = 1'b1;
               if (stat.last) begin
                  state_in = S_DRAIN;
                  drain_in = 2'd0;
               end
            end
         end
         S_DRAIN: begin
            // read, multiply and write back stages empty out
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd3) begin
               state_in = S_DONE;
            end
         end
         S_WAIT: begin
            // the cell read is issued here, its registered data is ready in S_DONE; loads and writes commit here
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         drain_ff  <= '0;
         st_ff     <= ST_OK;
         last_ff   <= 1'b0;
         mac_ff    <= 1'b0;
         upd_ff    <= 1'b0;
         rsp_valid <= 1'b0;
         t_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         drain_ff  <= drain_in;
         st_ff     <= st_in;
         last_ff   <= last_in;
         // pipeline: read issue -> ram data -> product -> update
         mac_ff    <= cmd.rd;
         upd_ff    <= mac_ff;
         rsp_valid <= (state_ff == S_DONE);
         if (cmd.lat) begin
            t_ff <= req_type;
         end
      end
   end
endmodule

[rtl/convolutional_gridding_degridding_unit.sv]
// top level of the convolutional gridding and degridding unit
//
// command interface: a request transfer happens at a clock edge with start high
// and busy low; the fields are sampled at that edge
// one result per request: the rsp_ ports carry it for exactly one cycle,
// marked by rsp_valid; the receiver cannot stall, so nothing is held back
// csr_we writes the support half width S; the user writes it only while idle
// and the block does not enforce it; kernel load, cell read and cell write
// pass the wait and done states before the strobe, rejected windows and
// unknown types go straight to the done state; grid and degrid walk the
// (2S+1)^2 window at one complex mac per cycle, set by the one grid read port
// busy stays high from the transfer until the result strobe cycle
// reset: support returns to 3 and the grid memory is cleared by a pass over
// all 65536 cells, one cell per cycle, during which busy stays high
// the kernel table has no reset; loads must fill it before use (not enforced)
module convolutional_gridding_degridding_unit import cgd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_type,
   input  logic signed [15:0] req_sample_re,
   input  logic signed [15:0] req_sample_im,
   input  logic [7:0]         req_grid_u,
   input  logic [7:0]         req_grid_v,
   input  logic [16:0]        req_kernel_base,
   input  logic signed [31:0] req_cell_re,
   input  logic signed [31:0] req_cell_im,
   input  logic               csr_we,
   input  logic [2:0]         csr_support,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_re,
   output logic signed [31:0] rsp_result_im,
   output logic               rsp_saturated,
   output logic [1:0]         rsp_status
);
   cgd_cmd_type  cmd;
   cgd_stat_type stat;
   logic [2:0]   support_ff;
   logic [1:0]   fin_status;

   // support register, the field is never above the limit at this width
   always_ff @(posedge clock) begin
      if (reset) begin
         support_ff <= 3'd3;
      end else if (csr_we) begin
         support_ff <= csr_support;
      end
   end

   cgd_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_type(req_type),
      .grid_u(req_grid_u), .grid_v(req_grid_v), .kernel_base(req_kernel_base),
      .s_in(support_ff), .stat(stat), .cmd(cmd), .fin_status(fin_status),
      .busy(busy), .rsp_valid(rsp_valid));

   cgd_datapath u_dp (
      .clock(clock), .cmd(cmd), .stat(stat), .s_in(support_ff),
      .req_type(req_type), .sample_re(req_sample_re), .sample_im(req_sample_im),
      .grid_u(req_grid_u), .grid_v(req_grid_v), .kernel_base(req_kernel_base),
      .cell_re(req_cell_re), .cell_im(req_cell_im), .fin_status(fin_status),
      .rsp_result_re(rsp_result_re), .rsp_result_im(rsp_result_im),
      .rsp_saturated(rsp_saturated), .rsp_status(rsp_status));
endmodule
